### design/assert_macros.svh
// Assertion macros shared by exop_core and exop_out_reg
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset
`define EXOP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, held off during reset
`define EXOP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### design/exop_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exop_pkg
// Types, constants and helper functions of the Exif orientation parser.
// ----------------------------------------------------------------------------
package exop_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_FLIP_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_FLIP_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ROTATE = 2'd2;

  localparam logic [15:0] TAG_ORIENT   = 16'h0112;
  localparam logic [31:0] TIFF_LE_HDR  = 32'h4949_2A00;
  localparam logic [31:0] TIFF_BE_HDR  = 32'h4D4D_002A;
  localparam logic [3:0]  EXIF_SIG_LEN = 4'd6;
  localparam logic [3:0]  WORD32_LEN   = 4'd4;
  localparam logic [3:0]  WORD16_LEN   = 4'd2;
  localparam logic [3:0]  ENTRY_LEN    = 4'd12;
  localparam logic [3:0]  VAL_HI_IDX   = 4'd8;
  localparam logic [3:0]  VAL_LO_IDX   = 4'd9;
  localparam logic [15:0] LEN_FIELD    = 16'd2;
  localparam logic [31:0] TIFF_HDR_LEN = 32'd8;

  typedef enum logic [3:0] {
    PH_LEN_HI = 4'd0,
    PH_LEN_LO = 4'd1,
    PH_EXIF   = 4'd2,
    PH_TIFF   = 4'd3,
    PH_OFFSET = 4'd4,
    PH_SKIP   = 4'd5,
    PH_COUNT  = 4'd6,
    PH_TAG    = 4'd7,
    PH_DRAIN  = 4'd8
  } exop_phase_t;

  typedef struct packed {
    logic rotate;
    logic flip_y;
    logic flip_x;
  } exop_flags_t;

  typedef struct packed {
    logic        status;
    exop_flags_t flags;
    logic [15:0] orientation;
  } exop_res_t;

  function automatic logic [7:0] exif_sig(input logic [2:0] idx);
    logic [7:0] s;
    case (idx)
      3'd0:    s = 8'h45;
      3'd1:    s = 8'h78;
      3'd2:    s = 8'h69;
      3'd3:    s = 8'h66;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  function automatic logic [15:0] swap16(input logic [15:0] v);
    return {v[7:0], v[15:8]};
  endfunction

  function automatic logic [31:0] swap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic exop_flags_t apply_orient(input exop_flags_t f,
                                               input logic [15:0] o);
    exop_flags_t r;
    r = f;
    case (o)
      16'd2: r.flip_x = 1'b1;
      16'd3: begin
        r.flip_x = 1'b1;
        r.flip_y = ~f.flip_y;
      end
      16'd4: r.flip_y = ~f.flip_y;
      16'd5: r.rotate = 1'b1;
      16'd6: begin
        r.rotate = 1'b1;
        r.flip_x = 1'b1;
      end
      16'd7: begin
        r.rotate = 1'b1;
        r.flip_x = 1'b1;
        r.flip_y = ~f.flip_y;
      end
      16'd8: begin
        r.rotate = 1'b1;
        r.flip_y = ~f.flip_y;
      end
      default: r = f;
    endcase
    return r;
  endfunction

endpackage

### design/exop_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exop_cfg
// Base flag registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module exop_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [exop_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                           cfg_data,
  output exop_pkg::exop_flags_t          base
);
  import exop_pkg::*;

  exop_flags_t base_r, base_nxt;

  assign cfg_ready = 1'b1;
  assign base      = base_r;

  always_comb begin
    base_nxt = base_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_BASE_FLIP_X: base_nxt.flip_x = cfg_data;
        CFG_BASE_FLIP_Y: base_nxt.flip_y = cfg_data;
        CFG_BASE_ROTATE: base_nxt.rotate = cfg_data;
        default:         base_nxt = base_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else begin
      base_r <= base_nxt;
    end
  end

endmodule

### design/exop_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// exop_core
// Per-byte parse state and its combinational update: length, Exif magic,
// TIFF header, IFD offset, skip, tag count, tag entry scan and drain.
// ----------------------------------------------------------------------------
module exop_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  logic [7:0]            data_byte,
  input  logic                  source_end,
  input  exop_pkg::exop_flags_t base,
  output logic                  emit,
  output exop_pkg::exop_res_t   res
);
  import exop_pkg::*;

  exop_phase_t phase_r, phase_nxt;
  logic [15:0] remaining_r, remaining_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [31:0] field_r, field_nxt;
  logic        le_r, le_nxt;
  logic [15:0] skip_r, skip_nxt;
  logic [15:0] tags_r, tags_nxt;
  logic [15:0] cur_r, cur_nxt;
  exop_flags_t flags_r, flags_nxt;
  logic [15:0] found_r, found_nxt;

  logic        drain_v, count_v, tags_v, emit_v, status_v;
  logic [15:0] len_v;
  logic [31:0] off_v, off_rel_v;
  logic [16:0] tag_budget;

  always_comb begin
    phase_nxt     = phase_r;
    remaining_nxt = remaining_r;
    idx_nxt       = idx_r;
    field_nxt     = field_r;
    le_nxt        = le_r;
    skip_nxt      = skip_r;
    tags_nxt      = tags_r;
    cur_nxt       = cur_r;
    flags_nxt     = flags_r;
    found_nxt     = found_r;
    drain_v       = 1'b0;
    count_v       = 1'b0;
    tags_v        = 1'b0;
    emit_v        = 1'b0;
    status_v      = 1'b0;
    len_v         = {field_r[7:0], data_byte};
    off_v         = le_r ? swap32({field_r[23:0], data_byte}) : {field_r[23:0], data_byte};
    off_rel_v     = off_v - TIFF_HDR_LEN;
    if (step_en) begin
      if (source_end) begin
        if (phase_r == PH_LEN_HI) begin
          flags_nxt = base;
          found_nxt = '0;
        end
        emit_v   = 1'b1;
        status_v = 1'b1;
      end else begin
        case (phase_r)
          PH_LEN_HI: begin
            flags_nxt = base;
            found_nxt = '0;
            field_nxt = {24'd0, data_byte};
            phase_nxt = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            remaining_nxt = (len_v >= LEN_FIELD) ? len_v - LEN_FIELD : '0;
            if (remaining_nxt < 16'd6) begin
              drain_v = 1'b1;
            end else begin
              phase_nxt = PH_EXIF;
              idx_nxt   = '0;
              field_nxt = '0;
            end
          end
          PH_EXIF: begin
            remaining_nxt = remaining_r - 16'd1;
            if (data_byte != exif_sig(idx_r[2:0])) begin
              field_nxt = 32'd1;
            end
            idx_nxt = idx_r + 4'd1;
            if (idx_nxt == EXIF_SIG_LEN) begin
              if ((field_nxt != '0) || (remaining_nxt < 16'd4)) begin
                drain_v = 1'b1;
              end else begin
                phase_nxt = PH_TIFF;
                idx_nxt   = '0;
                field_nxt = '0;
              end
            end
          end
          PH_TIFF: begin
            remaining_nxt = remaining_r - 16'd1;
            field_nxt     = {field_r[23:0], data_byte};
            idx_nxt       = idx_r + 4'd1;
            if (idx_nxt == WORD32_LEN) begin
              if (field_nxt == TIFF_LE_HDR) begin
                le_nxt = 1'b1;
              end else if (field_nxt == TIFF_BE_HDR) begin
                le_nxt = 1'b0;
              end
              if (((field_nxt != TIFF_LE_HDR) && (field_nxt != TIFF_BE_HDR)) ||
                  (remaining_nxt < 16'd4)) begin
                drain_v = 1'b1;
              end else begin
                phase_nxt = PH_OFFSET;
                idx_nxt   = '0;
                field_nxt = '0;
              end
            end
          end
          PH_OFFSET: begin
            remaining_nxt = remaining_r - 16'd1;
            field_nxt     = {field_r[23:0], data_byte};
            idx_nxt       = idx_r + 4'd1;
            if (idx_nxt == WORD32_LEN) begin
              if ((off_v < TIFF_HDR_LEN) || (off_rel_v > {16'd0, remaining_nxt})) begin
                drain_v = 1'b1;
              end else begin
                skip_nxt = off_rel_v[15:0];
                if (skip_nxt == '0) begin
                  count_v = 1'b1;
                end else begin
                  phase_nxt = PH_SKIP;
                end
              end
            end
          end
          PH_SKIP: begin
            if (remaining_r != '0) remaining_nxt = remaining_r - 16'd1;
            if (skip_r != '0) skip_nxt = skip_r - 16'd1;
            if (skip_nxt == '0) count_v = 1'b1;
          end
          PH_COUNT: begin
            remaining_nxt = remaining_r - 16'd1;
            field_nxt     = {16'd0, field_r[7:0], data_byte};
            idx_nxt       = idx_r + 4'd1;
            if (idx_nxt == WORD16_LEN) begin
              tags_nxt = le_r ? swap16(field_nxt[15:0]) : field_nxt[15:0];
              tags_v   = 1'b1;
            end
          end
          PH_TAG: begin
            remaining_nxt = remaining_r - 16'd1;
            if (idx_r < WORD16_LEN) begin
              cur_nxt = {cur_r[7:0], data_byte};
            end else if ((idx_r == VAL_HI_IDX) || (idx_r == VAL_LO_IDX)) begin
              field_nxt = {16'd0, field_r[7:0], data_byte};
            end
            idx_nxt = idx_r + 4'd1;
            if (idx_nxt == ENTRY_LEN) begin
              if (tags_r != '0) tags_nxt = tags_r - 16'd1;
              if (le_r) begin
                cur_nxt   = swap16(cur_nxt);
                field_nxt = {16'd0, swap16(field_nxt[15:0])};
              end
              if (cur_nxt == TAG_ORIENT) begin
                found_nxt = field_nxt[15:0];
                flags_nxt = apply_orient(flags_r, field_nxt[15:0]);
                drain_v   = 1'b1;
              end else begin
                tags_v = 1'b1;
              end
            end
          end
          PH_DRAIN: begin
            if (remaining_r != '0) remaining_nxt = remaining_r - 16'd1;
            if (remaining_nxt == '0) emit_v = 1'b1;
          end
          default: begin
            phase_nxt = PH_LEN_HI;
          end
        endcase
      end
      if (count_v) begin
        if (remaining_nxt < 16'd2) begin
          drain_v = 1'b1;
        end else begin
          phase_nxt = PH_COUNT;
          idx_nxt   = '0;
          field_nxt = '0;
        end
      end
      if (tags_v) begin
        if ((tags_nxt == '0) || (remaining_nxt < 16'd12)) begin
          drain_v = 1'b1;
        end else begin
          phase_nxt = PH_TAG;
          idx_nxt   = '0;
          field_nxt = '0;
          cur_nxt   = '0;
        end
      end
      if (drain_v) begin
        if (remaining_nxt == '0) begin
          emit_v = 1'b1;
        end else begin
          phase_nxt = PH_DRAIN;
        end
      end
      if (emit_v) begin
        phase_nxt = PH_LEN_HI;
      end
    end
  end

  assign emit            = emit_v;
  assign res.status      = status_v;
  assign res.flags       = flags_nxt;
  assign res.orientation = found_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LEN_HI;
      remaining_r <= '0;
      idx_r       <= '0;
      field_r     <= '0;
      le_r        <= 1'b0;
      skip_r      <= '0;
      tags_r      <= '0;
      cur_r       <= '0;
      flags_r     <= '0;
      found_r     <= '0;
    end else begin
      phase_r     <= phase_nxt;
      remaining_r <= remaining_nxt;
      idx_r       <= idx_nxt;
      field_r     <= field_nxt;
      le_r        <= le_nxt;
      skip_r      <= skip_nxt;
      tags_r      <= tags_nxt;
      cur_r       <= cur_nxt;
      flags_r     <= flags_nxt;
      found_r     <= found_nxt;
    end
  end

  assign tag_budget = {1'b0, remaining_r} + {13'd0, idx_r};

  `EXOP_ASSERT_IMPL(a_idx_range, 1'b1, idx_r <= ENTRY_LEN)
  `EXOP_ASSERT_IMPL(a_drain_nonzero, phase_r == PH_DRAIN, remaining_r != '0)
  `EXOP_ASSERT_IMPL(a_tag_budget, phase_r == PH_TAG, tag_budget >= {13'd0, ENTRY_LEN})
  `EXOP_ASSERT_NEXT(a_emit_restart, step_en && emit, phase_r == PH_LEN_HI)

endmodule

### design/exop_out_reg.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// exop_out_reg
// Result register: holds one result until the output transaction completes.
// ----------------------------------------------------------------------------
module exop_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  exop_pkg::exop_res_t res_in,
  output logic                free,
  output logic                out_valid,
  input  logic                out_ready,
  output exop_pkg::exop_res_t res_out
);
  import exop_pkg::*;

  logic      valid_r, valid_nxt;
  exop_res_t res_r;

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign res_out   = res_r;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  `EXOP_ASSERT_IMPL(a_load_free, load, free)
  `EXOP_ASSERT_NEXT(a_load_valid, load, valid_r)

endmodule

### design/exif_orientation_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exif_orientation_parser
// Scans a JPEG APP1 segment byte by byte for the Exif orientation tag and
// reports the resulting flip and rotate flags once per segment.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; in_ready drops only while a result is held
//   and out_ready is low.
// Output: the result is registered and on the output in the cycle after the byte
//   (or source end) that closes the segment is accepted.
// Reset: synchronous, active low; clears parse state, base flags and the
//   result register valid. No clearing pass.
module exif_orientation_parser (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_data_byte,
  input  logic                           in_source_end,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_status,
  output logic                           out_flip_x,
  output logic                           out_flip_y,
  output logic                           out_rotate,
  output logic [15:0]                    out_orientation,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [exop_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                           cfg_data
);
  import exop_pkg::*;

  exop_flags_t base;
  exop_res_t   core_res;
  exop_res_t   out_res;
  logic        step_en;
  logic        emit;
  logic        free;

  assign in_ready = free;
  assign step_en  = in_valid && in_ready;

  exop_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .base      (base)
  );

  exop_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (step_en),
    .data_byte  (in_data_byte),
    .source_end (in_source_end),
    .base       (base),
    .emit       (emit),
    .res        (core_res)
  );

  exop_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step_en && emit),
    .res_in    (core_res),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (out_res)
  );

  assign out_status      = out_res.status;
  assign out_flip_x      = out_res.flags.flip_x;
  assign out_flip_y      = out_res.flags.flip_y;
  assign out_rotate      = out_res.flags.rotate;
  assign out_orientation = out_res.orientation;

endmodule
